[sv/id3tfe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Types, frame IDs and field lengths shared by the text frame extractor.
// ----------------------------------------------------------------------------
package id3tfe_pkg;

    // Tag header and frame header field lengths in bytes
    localparam int HEADER_BYTES = 10;
    localparam int ID_BYTES     = 4;
    localparam int SIZE_BYTES   = 4;
    localparam int FLAG_BYTES   = 2;

    localparam int NUM_KINDS = 6;

    // Text frame IDs, in tag_kind order
    localparam logic [31:0] KIND_IDS [NUM_KINDS] = '{
        32'h5449_5432,  // TIT2 title
        32'h5459_4552,  // TYER year
        32'h5450_4531,  // TPE1 artist
        32'h5441_4C42,  // TALB album
        32'h5443_4F4E,  // TCON genre
        32'h434F_4D4D   // COMM comment
    };

    // Configuration register indexes
    localparam logic CFG_TEXT_LIMIT   = 1'b0;
    localparam logic CFG_WANTED_COUNT = 1'b1;

    localparam logic [7:0] TEXT_LIMIT_RESET   = 8'd98;
    localparam logic [2:0] WANTED_COUNT_RESET = 3'd6;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ID     = 3'd1,
        PH_SIZE   = 3'd2,
        PH_FLAGS  = 3'd3,
        PH_ENC    = 3'd4,
        PH_BODY   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [2:0] tag_kind;
        logic [7:0] text_byte;
        logic       empty_text;
        logic       last_byte;
        logic       all_found;
    } t_result;

    // Returns kind plus one for a text frame ID, zero for anything else
    function automatic logic [2:0] lookup_kind(input logic [31:0] id);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 0; i < NUM_KINDS; i++) begin
            if (id == KIND_IDS[i]) begin
                k = 3'(i + 1);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

[sv/id3tfe_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// id3tfe_parser
// Byte-wide frame parser: header skip, frame header capture, text emission.
// ----------------------------------------------------------------------------
module id3tfe_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_sof,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    output logic                      o_res_valid,
    output id3tfe_pkg::t_result       o_res
);

    id3tfe_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_id, n_id;
    logic [31:0] r_size, n_size;
    logic [31:0] r_rem, n_rem;
    logic [7:0]  r_emitted, n_emitted;
    logic [2:0]  r_matched, n_matched;
    logic [2:0]  r_found, n_found;
    logic [7:0]  r_text_limit;
    logic [2:0]  r_wanted;

    // Start of file restarts the parser on this very byte
    id3tfe_pkg::t_phase cur_phase;
    logic [3:0]  cur_cnt;
    logic [31:0] cur_id, cur_size, cur_rem;
    logic [7:0]  cur_emitted;
    logic [2:0]  cur_matched, cur_found;

    logic [7:0]  limit;
    logic [2:0]  want;
    logic [3:0]  cnt_inc;
    logic [2:0]  found_inc;
    logic        done_hit;
    logic [2:0]  kind_hit;
    logic [31:0] rem_dec;
    logic [7:0]  emitted_inc;
    logic        last;

    always_comb begin
        cur_phase   = i_sof ? id3tfe_pkg::PH_HEADER : r_phase;
        cur_cnt     = i_sof ? 4'd0  : r_cnt;
        cur_id      = i_sof ? 32'd0 : r_id;
        cur_size    = i_sof ? 32'd0 : r_size;
        cur_rem     = i_sof ? 32'd0 : r_rem;
        cur_emitted = i_sof ? 8'd0  : r_emitted;
        cur_matched = i_sof ? 3'd0  : r_matched;
        cur_found   = i_sof ? 3'd0  : r_found;

        limit       = (r_text_limit == 8'd0) ? 8'd1 : r_text_limit;
        want        = (r_wanted == 3'd0) ? 3'd1 : r_wanted;
        cnt_inc     = cur_cnt + 4'd1;
        found_inc   = (cur_found == 3'd7) ? cur_found : cur_found + 3'd1;
        done_hit    = (found_inc >= want);
        kind_hit    = id3tfe_pkg::lookup_kind(cur_id);
        rem_dec     = cur_rem - 32'd1;
        emitted_inc = cur_emitted + 8'd1;
        last        = (emitted_inc >= limit) || (rem_dec == 32'd0);

        n_phase     = cur_phase;
        n_cnt       = cur_cnt;
        n_id        = cur_id;
        n_size      = cur_size;
        n_rem       = cur_rem;
        n_emitted   = cur_emitted;
        n_matched   = cur_matched;
        n_found     = cur_found;

        o_res_valid      = 1'b0;
        o_res.tag_kind   = cur_matched - 3'd1;
        o_res.text_byte  = i_byte;
        o_res.empty_text = 1'b0;
        o_res.last_byte  = 1'b0;
        o_res.all_found  = 1'b0;

        case (cur_phase)
            id3tfe_pkg::PH_HEADER: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'(id3tfe_pkg::HEADER_BYTES)) begin
                    n_cnt   = 4'd0;
                    n_phase = id3tfe_pkg::PH_ID;
                end
            end
            id3tfe_pkg::PH_ID: begin
                n_id  = {cur_id[23:0], i_byte};
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'(id3tfe_pkg::ID_BYTES)) begin
                    n_cnt   = 4'd0;
                    n_phase = id3tfe_pkg::PH_SIZE;
                end
            end
            id3tfe_pkg::PH_SIZE: begin
                n_size = {cur_size[23:0], i_byte};
                n_cnt  = cnt_inc;
                if (cnt_inc >= 4'(id3tfe_pkg::SIZE_BYTES)) begin
                    n_cnt   = 4'd0;
                    n_phase = id3tfe_pkg::PH_FLAGS;
                end
            end
            id3tfe_pkg::PH_FLAGS: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'(id3tfe_pkg::FLAG_BYTES)) begin
                    n_cnt   = 4'd0;
                    // size-zero frames have no encoding byte
                    n_phase = (cur_size != 32'd0) ? id3tfe_pkg::PH_ENC
                                                  : id3tfe_pkg::PH_ID;
                end
            end
            id3tfe_pkg::PH_ENC: begin
                n_matched = kind_hit;
                n_rem     = cur_size - 32'd1;
                n_emitted = 8'd0;
                if (n_rem != 32'd0) begin
                    n_phase = id3tfe_pkg::PH_BODY;
                end else begin
                    n_phase = id3tfe_pkg::PH_ID;
                    if (kind_hit != 3'd0) begin
                        // matched frame holding only the encoding byte
                        o_res_valid      = 1'b1;
                        o_res.tag_kind   = kind_hit - 3'd1;
                        o_res.text_byte  = 8'd0;
                        o_res.empty_text = 1'b1;
                        o_res.last_byte  = 1'b1;
                        o_res.all_found  = done_hit;
                        n_found          = found_inc;
                        if (done_hit) begin
                            n_phase = id3tfe_pkg::PH_DONE;
                        end
                    end
                end
            end
            id3tfe_pkg::PH_BODY: begin
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = id3tfe_pkg::PH_ID;
                end
                if (cur_matched != 3'd0 && cur_emitted < limit) begin
                    o_res_valid     = 1'b1;
                    o_res.last_byte = last;
                    n_emitted       = emitted_inc;
                    if (last) begin
                        n_found         = found_inc;
                        o_res.all_found = done_hit;
                        if (done_hit) begin
                            n_phase = id3tfe_pkg::PH_DONE;
                        end
                    end
                end
            end
            id3tfe_pkg::PH_DONE: begin
                // ignore bytes until the next start of file
            end
            default: begin
                n_phase = id3tfe_pkg::PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= id3tfe_pkg::PH_HEADER;
            r_cnt     <= 4'd0;
            r_id      <= 32'd0;
            r_size    <= 32'd0;
            r_rem     <= 32'd0;
            r_emitted <= 8'd0;
            r_matched <= 3'd0;
            r_found   <= 3'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_id      <= n_id;
            r_size    <= n_size;
            r_rem     <= n_rem;
            r_emitted <= n_emitted;
            r_matched <= n_matched;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_limit <= id3tfe_pkg::TEXT_LIMIT_RESET;
            r_wanted     <= id3tfe_pkg::WANTED_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                id3tfe_pkg::CFG_TEXT_LIMIT:   r_text_limit <= i_cfg_data;
                id3tfe_pkg::CFG_WANTED_COUNT: r_wanted     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/id3tfe_out_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// id3tfe_out_skid
// Result register with a skid stage so input acceptance survives a stall.
// ----------------------------------------------------------------------------
module id3tfe_out_skid (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire id3tfe_pkg::t_result  i_push_data,
    output logic                      o_ready,
    output logic                      o_valid,
    output id3tfe_pkg::t_result       o_data,
    input  wire logic                 i_take_ready
);

    logic                r_main_valid;
    logic                r_skid_valid;
    id3tfe_pkg::t_result r_main;
    id3tfe_pkg::t_result r_skid;
    logic                main_free;

    assign main_free = !r_main_valid || i_take_ready;
    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            // drain the skid first; no push can arrive while it is full
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule
`default_nettype wire

[sv/id3v2_text_frame_extractor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor
// Pulls the text of title, year, artist, album, genre and comment frames
// out of a byte stream of a tagged MP3 file.
//
// Slave stream: one file byte per beat in s_tdata, s_tuser set on the first
// byte of a file to restart parsing. Master stream: one result per beat,
// tuser carries the tag kind, tlast marks the final result of a frame.
// Configuration: i_cfg_we with i_cfg_index 0 writes the text limit, index 1
// the wanted frame count; write only while no beat is in flight.
// Throughput: one byte per cycle while s_tready is high. The parser state
// advances on each accepted byte, and its result is registered in the
// result register, or in the skid stage while the receiver stalls.
// Reset clears the parser, empties the output stage and loads text limit 98
// and wanted count 6. When the receiver stalls, the result register holds
// and one more result goes into the skid stage; s_tready drops only while
// the skid stage is full, and bytes that make no result are still taken.
// ----------------------------------------------------------------------------
module id3v2_text_frame_extractor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] start_of_file
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] text_byte, [8] empty_text,
                                          // [9] all_found, [15:10] zero
    output logic [2:0]       o_m_tuser,   // [2:0] tag_kind
    output logic             o_m_tlast,   // last_byte
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic                accept;
    logic                res_valid;
    id3tfe_pkg::t_result res;
    id3tfe_pkg::t_result out_res;

    assign accept = i_s_tvalid && o_s_tready;

    id3tfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_sof       (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    id3tfe_out_skid u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && res_valid),
        .i_push_data  (res),
        .o_ready      (o_s_tready),
        .o_valid      (o_m_tvalid),
        .o_data       (out_res),
        .i_take_ready (i_m_tready)
    );

    assign o_m_tdata = {6'd0, out_res.all_found, out_res.empty_text, out_res.text_byte};
    assign o_m_tuser = out_res.tag_kind;
    assign o_m_tlast = out_res.last_byte;

    // the closing result of the final wanted frame ends its frame
    a_all_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9] |-> o_m_tlast)
        else $error("all_found without last_byte");

    // an empty frame gives a single zero byte result
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tlast && (o_m_tdata[7:0] == 8'd0))
        else $error("empty result not last or nonzero");

    // the skid stage only fills behind a full result register
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser != 3'd6) && (o_m_tuser != 3'd7))
        else $error("tag kind out of range");

endmodule
`default_nettype wire
